/* design/eme_pkg.sv */
package eme_pkg;

  localparam int unsigned BlockLen     = 128;
  localparam int unsigned DefMaxModes  = 32;
  localparam int unsigned DivSteps     = 30;
  localparam int unsigned PclkScale    = 10000;
  localparam int unsigned StdRefBase   = 60;
  localparam int unsigned StdWidthBase = 248;
  localparam int unsigned Recip5       = 52429;
  localparam int unsigned Recip5Shift  = 18;

  localparam logic [1:0] StatusMode    = 2'd0;
  localparam logic [1:0] StatusInvalid = 2'd1;
  localparam logic [1:0] StatusNoModes = 2'd2;

  typedef struct packed {
    logic [11:0] width;
    logic [11:0] height;
    logic [29:0] refresh;
  } mode_t;

  typedef struct packed {
    logic       in_ready;
    logic [6:0] byte_raddr;
    logic       slot_we;
    logic [3:0] slot_idx;
    logic       run_init;
    logic       desc_tot;
    logic       first_desc;
    logic       div_start;
    logic       desc_cand;
    logic       std_cand;
    logic       est_cand;
    logic [4:0] est_idx;
    logic       mode_we;
    logic       out_load;
    logic [1:0] out_kind;
    logic       out_first;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    logic final_acc;
    logic blk_ok;
    logic desc_skip;
    logic std_skip;
    logic est_bit;
    logic div_done;
    logic mode_match;
    logic out_free;
  } sts_t;

  function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
    logic [7:0] b;
    b = ((idx == 3'd0) || (idx == 3'd7)) ? 8'h00 : 8'hFF;
    return b;
  endfunction

  function automatic mode_t est_mode(input logic [4:0] idx);
    mode_t m;
    m = '0;
    case (idx)
      5'd0:  m = '{12'd1152, 12'd870,  30'd75};
      5'd1:  m = '{12'd1280, 12'd1024, 30'd75};
      5'd2:  m = '{12'd1024, 12'd768,  30'd75};
      5'd3:  m = '{12'd1024, 12'd768,  30'd70};
      5'd4:  m = '{12'd1024, 12'd768,  30'd60};
      5'd5:  m = '{12'd1024, 12'd768,  30'd87};
      5'd6:  m = '{12'd832,  12'd624,  30'd75};
      5'd7:  m = '{12'd800,  12'd600,  30'd75};
      5'd8:  m = '{12'd800,  12'd600,  30'd72};
      5'd9:  m = '{12'd800,  12'd600,  30'd60};
      5'd10: m = '{12'd800,  12'd600,  30'd56};
      5'd11: m = '{12'd640,  12'd480,  30'd75};
      5'd12: m = '{12'd640,  12'd480,  30'd72};
      5'd13: m = '{12'd640,  12'd480,  30'd67};
      5'd14: m = '{12'd640,  12'd480,  30'd60};
      5'd15: m = '{12'd720,  12'd400,  30'd88};
      5'd16: m = '{12'd720,  12'd400,  30'd70};
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

/* design/eme_ram.sv */
module eme_ram
#(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* design/eme_ctrl.sv */
module eme_ctrl
  import eme_pkg::*;
#(
  parameter int unsigned MaxModes = DefMaxModes,
  localparam int unsigned Aw = (MaxModes > 1) ? $clog2(MaxModes) : 1,
  localparam int unsigned Cw = $clog2(MaxModes + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  sts_t          sts_i,
  output cmd_t          cmd_o,
  output logic [Aw-1:0] mode_waddr_o,
  output logic [Aw-1:0] mode_raddr_o
);

  localparam logic [3:0] StLoad     = 4'd0;
  localparam logic [3:0] StCheck    = 4'd1;
  localparam logic [3:0] StFetchRd  = 4'd2;
  localparam logic [3:0] StFetchLat = 4'd3;
  localparam logic [3:0] StEval     = 4'd4;
  localparam logic [3:0] StMul      = 4'd5;
  localparam logic [3:0] StDiv      = 4'd6;
  localparam logic [3:0] StAdd      = 4'd7;
  localparam logic [3:0] StScanRd   = 4'd8;
  localparam logic [3:0] StScanCmp  = 4'd9;
  localparam logic [3:0] StNext     = 4'd10;
  localparam logic [3:0] StEmit     = 4'd11;
  localparam logic [3:0] StEmitWait = 4'd12;

  localparam logic [1:0] PhDesc = 2'd0;
  localparam logic [1:0] PhStd  = 2'd1;
  localparam logic [1:0] PhEst  = 2'd2;

  localparam logic [6:0] DescBase   = 7'd54;
  localparam logic [6:0] DescStride = 7'd18;
  localparam logic [6:0] DescFlagOf = 7'd17;
  localparam logic [6:0] StdBase    = 7'd38;
  localparam logic [3:0] DescLastJ  = 4'd8;
  localparam logic [3:0] StdLastJ   = 4'd1;
  localparam logic [4:0] DescLast   = 5'd3;
  localparam logic [4:0] StdLast    = 5'd7;
  localparam logic [4:0] EstLast    = 5'd16;
  localparam logic [4:0] EstIlaced  = 5'd5;

  logic [3:0]    state_q, state_d;
  logic [1:0]    phase_q, phase_d;
  logic [4:0]    idx_q, idx_d;
  logic [3:0]    j_q, j_d;
  logic [Cw-1:0] total_q, total_d;
  logic [Cw-1:0] k_q, k_d;
  logic [6:0]    fetch_addr;
  logic [3:0]    last_j;
  logic          k_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      phase_q <= PhDesc;
      idx_q   <= '0;
      j_q     <= '0;
      total_q <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
      j_q     <= j_d;
      total_q <= total_d;
      k_q     <= k_d;
    end
  end

  always_comb begin
    if (phase_q == PhDesc) begin
      fetch_addr = DescBase + 7'(idx_q) * DescStride
                 + ((j_q == DescLastJ) ? DescFlagOf : 7'(j_q));
      last_j     = DescLastJ;
    end else begin
      fetch_addr = StdBase + 7'({idx_q, 1'b0}) + 7'(j_q);
      last_j     = StdLastJ;
    end
  end

  assign k_last       = ((k_q + Cw'(1)) == total_q);
  assign mode_waddr_o = total_q[Aw-1:0];
  assign mode_raddr_o = k_q[Aw-1:0];

  always_comb begin
    state_d = state_q;
    phase_d = phase_q;
    idx_d   = idx_q;
    j_d     = j_q;
    total_d = total_q;
    k_d     = k_q;
    cmd_o            = '0;
    cmd_o.byte_raddr = fetch_addr;
    cmd_o.slot_idx   = j_q;
    cmd_o.est_idx    = idx_q;
    cmd_o.out_first  = (k_q == '0);
    cmd_o.out_kind   = StatusMode;
    case (state_q)
      StLoad: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.final_acc) begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (!sts_i.blk_ok) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = StatusInvalid;
            cmd_o.out_last = 1'b1;
            state_d        = StLoad;
          end
        end else begin
          cmd_o.run_init = 1'b1;
          phase_d = PhDesc;
          idx_d   = '0;
          j_d     = '0;
          total_d = '0;
          state_d = StFetchRd;
        end
      end
      StFetchRd: begin
        state_d = StFetchLat;
      end
      StFetchLat: begin
        cmd_o.slot_we = 1'b1;
        if (j_q == last_j) begin
          j_d     = '0;
          state_d = StEval;
        end else begin
          j_d     = j_q + 4'd1;
          state_d = StFetchRd;
        end
      end
      StEval: begin
        state_d = StNext;
        case (phase_q)
          PhDesc: begin
            if (!sts_i.desc_skip) begin
              cmd_o.desc_tot   = 1'b1;
              cmd_o.first_desc = (idx_q == '0);
              state_d          = StMul;
            end
          end
          PhStd: begin
            if (!sts_i.std_skip) begin
              cmd_o.std_cand = 1'b1;
              state_d        = StAdd;
            end
          end
          PhEst: begin
            if (sts_i.est_bit && (idx_q != EstIlaced)) begin
              cmd_o.est_cand = 1'b1;
              state_d        = StAdd;
            end
          end
          default: state_d = StNext;
        endcase
      end
      StMul: begin
        cmd_o.div_start = 1'b1;
        state_d         = StDiv;
      end
      StDiv: begin
        if (sts_i.div_done) begin
          cmd_o.desc_cand = 1'b1;
          state_d         = StAdd;
        end
      end
      StAdd: begin
        if (total_q == Cw'(MaxModes)) begin
          state_d = StNext;
        end else if (total_q == '0) begin
          cmd_o.mode_we = 1'b1;
          total_d       = total_q + Cw'(1);
          state_d       = StNext;
        end else begin
          k_d     = '0;
          state_d = StScanRd;
        end
      end
      StScanRd: begin
        state_d = StScanCmp;
      end
      StScanCmp: begin
        if (sts_i.mode_match) begin
          state_d = StNext;
        end else if (k_last) begin
          cmd_o.mode_we = 1'b1;
          total_d       = total_q + Cw'(1);
          state_d       = StNext;
        end else begin
          k_d     = k_q + Cw'(1);
          state_d = StScanRd;
        end
      end
      StNext: begin
        j_d = '0;
        case (phase_q)
          PhDesc: begin
            state_d = StFetchRd;
            if (idx_q == DescLast) begin
              phase_d = PhStd;
              idx_d   = '0;
            end else begin
              idx_d = idx_q + 5'd1;
            end
          end
          PhStd: begin
            if (idx_q == StdLast) begin
              phase_d = PhEst;
              idx_d   = '0;
              state_d = StEval;
            end else begin
              idx_d   = idx_q + 5'd1;
              state_d = StFetchRd;
            end
          end
          PhEst: begin
            if (idx_q == EstLast) begin
              k_d     = '0;
              state_d = StEmit;
            end else begin
              idx_d   = idx_q + 5'd1;
              state_d = StEval;
            end
          end
          default: state_d = StLoad;
        endcase
      end
      StEmit: begin
        if (total_q == '0) begin
          if (sts_i.out_free) begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_kind = StatusNoModes;
            cmd_o.out_last = 1'b1;
            state_d        = StLoad;
          end
        end else begin
          state_d = StEmitWait;
        end
      end
      StEmitWait: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_last = k_last;
          if (k_last) begin
            state_d = StLoad;
          end else begin
            k_d     = k_q + Cw'(1);
            state_d = StEmit;
          end
        end
      end
      default: state_d = StLoad;
    endcase
  end

endmodule

/* design/eme_dp.sv */
module eme_dp
  import eme_pkg::*;
#(
  parameter int unsigned MaxModes = DefMaxModes,
  localparam int unsigned Aw = (MaxModes > 1) ? $clog2(MaxModes) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [7:0]    in_byte_i,
  input  logic          in_final_i,
  input  logic          out_ready_i,
  input  cmd_t          cmd_i,
  input  logic [Aw-1:0] mode_waddr_i,
  input  logic [Aw-1:0] mode_raddr_i,
  output sts_t          sts_o,
  output logic          out_valid_o,
  output logic [1:0]    out_status_o,
  output mode_t         out_mode_o,
  output logic          out_pref_o,
  output logic          out_last_o
);

  localparam logic [6:0] VerAddr  = 7'd18;
  localparam logic [6:0] RevAddr  = 7'd19;
  localparam logic [6:0] FeatAddr = 7'd24;
  localparam logic [6:0] Est0Addr = 7'd35;
  localparam logic [6:0] Est1Addr = 7'd36;
  localparam logic [6:0] Est2Addr = 7'd37;

  logic [7:0]  cnt_q;
  logic [7:0]  sum_q;
  logic        hdr_ok_q;
  logic        blk_ok_q;
  logic [7:0]  ver_q, rev_q, feat_q, est0_q, est1_q, est2_q;
  logic        accept, wr_en;
  logic [7:0]  cnt_new, sum_new;
  logic        hdr_new;

  logic [7:0]  slot_q [9];
  logic [7:0]  byte_rdata;
  logic        old_rev;
  logic        pref_q;
  logic [25:0] tot_q;
  logic [29:0] quo_q;
  logic [25:0] rem_q;
  logic [4:0]  div_cnt_q;
  logic        div_busy_q;
  mode_t       cand_q;
  mode_t       mode_rdata;

  logic [11:0] ha, hb, va, vb;
  logic [12:0] hsum, vsum;
  logic [15:0] pclk;
  logic [29:0] num;
  logic [26:0] trial;
  logic        trial_ge;
  logic [11:0] std_w, std_h;
  logic [15:0] w10, w9;
  logic [13:0] w3;
  logic [29:0] w4r;
  logic [16:0] sup;

  logic        out_valid_q;
  logic [1:0]  out_status_q;
  mode_t       out_mode_q;
  logic        out_pref_q;
  logic        out_last_q;

  assign accept  = in_valid_i && cmd_i.in_ready;
  assign wr_en   = accept && !cnt_q[7];
  assign cnt_new = wr_en ? (cnt_q + 8'd1) : cnt_q;
  assign sum_new = wr_en ? (sum_q + in_byte_i) : sum_q;
  assign hdr_new = hdr_ok_q && !(wr_en && (cnt_q < 8'd8)
                   && (in_byte_i != hdr_byte(cnt_q[2:0])));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      sum_q    <= '0;
      hdr_ok_q <= 1'b1;
      blk_ok_q <= 1'b0;
    end else if (accept) begin
      if (in_final_i) begin
        blk_ok_q <= (cnt_new == 8'(BlockLen)) && (sum_new == '0) && hdr_new;
        cnt_q    <= '0;
        sum_q    <= '0;
        hdr_ok_q <= 1'b1;
      end else begin
        cnt_q    <= cnt_new;
        sum_q    <= sum_new;
        hdr_ok_q <= hdr_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (cnt_q[6:0] == VerAddr)  ver_q  <= in_byte_i;
      if (cnt_q[6:0] == RevAddr)  rev_q  <= in_byte_i;
      if (cnt_q[6:0] == FeatAddr) feat_q <= in_byte_i;
      if (cnt_q[6:0] == Est0Addr) est0_q <= in_byte_i;
      if (cnt_q[6:0] == Est1Addr) est1_q <= in_byte_i;
      if (cnt_q[6:0] == Est2Addr) est2_q <= in_byte_i;
    end
  end

  eme_ram #(.Width(8), .Depth(BlockLen)) u_byte_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (cnt_q[6:0]),
    .wdata_i (in_byte_i),
    .raddr_i (cmd_i.byte_raddr),
    .rdata_o (byte_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.slot_we) begin
      slot_q[cmd_i.slot_idx] <= byte_rdata;
    end
  end

  assign old_rev = (ver_q == 8'd1) && (rev_q < 8'd3);
  assign pclk    = {slot_q[1], slot_q[0]};
  assign ha      = {slot_q[4][7:4], slot_q[2]};
  assign hb      = {slot_q[4][3:0], slot_q[3]};
  assign va      = {slot_q[7][7:4], slot_q[5]};
  assign vb      = {slot_q[7][3:0], slot_q[6]};
  assign hsum    = 13'(ha) + 13'(hb);
  assign vsum    = 13'(va) + 13'(vb);
  assign num     = 30'(pclk) * 30'(PclkScale) + 30'(tot_q >> 1);

  assign trial    = {rem_q, quo_q[29]};
  assign trial_ge = (trial >= {1'b0, tot_q});

  assign std_w = {1'b0, slot_q[0], 3'b000} + 12'(StdWidthBase);
  assign w10   = 16'(std_w) * 16'd10;
  assign w9    = 16'(std_w) * 16'd9;
  assign w3    = 14'(std_w) * 14'd3;
  assign w4r   = 30'({std_w, 2'b00}) * 30'(Recip5);

  always_comb begin
    case (slot_q[1][7:6])
      2'd0:    std_h = old_rev ? std_w : w10[15:4];
      2'd1:    std_h = w3[13:2];
      2'd2:    std_h = w4r[Recip5Shift+11:Recip5Shift];
      default: std_h = w9[15:4];
    endcase
  end

  assign sup = {est0_q, est1_q, est2_q[7]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      div_cnt_q  <= '0;
      pref_q     <= 1'b0;
    end else begin
      if (cmd_i.run_init) begin
        pref_q <= 1'b0;
      end else if (cmd_i.desc_tot && cmd_i.first_desc && (!old_rev || feat_q[1])) begin
        pref_q <= 1'b1;
      end
      if (cmd_i.div_start) begin
        div_busy_q <= 1'b1;
        div_cnt_q  <= 5'(DivSteps);
      end else if (div_busy_q) begin
        div_cnt_q <= div_cnt_q - 5'd1;
        if (div_cnt_q == 5'd1) begin
          div_busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.desc_tot) begin
      tot_q <= 26'(hsum) * 26'(vsum);
    end
    if (cmd_i.div_start) begin
      quo_q <= num;
      rem_q <= '0;
    end else if (div_busy_q) begin
      rem_q <= trial_ge ? 26'(trial - {1'b0, tot_q}) : trial[25:0];
      quo_q <= {quo_q[28:0], trial_ge};
    end
    if (cmd_i.desc_cand) begin
      cand_q <= '{ha, va, (tot_q == '0) ? 30'd0 : quo_q};
    end else if (cmd_i.std_cand) begin
      cand_q <= '{std_w, std_h, 30'(slot_q[1][5:0]) + 30'(StdRefBase)};
    end else if (cmd_i.est_cand) begin
      cand_q <= est_mode(cmd_i.est_idx);
    end
  end

  eme_ram #(.Width($bits(mode_t)), .Depth(MaxModes)) u_mode_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.mode_we),
    .waddr_i (mode_waddr_i),
    .wdata_i (cand_q),
    .raddr_i (mode_raddr_i),
    .rdata_o (mode_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_kind;
      out_last_q   <= cmd_i.out_last;
      if (cmd_i.out_kind == StatusMode) begin
        out_mode_q <= mode_rdata;
        out_pref_q <= cmd_i.out_first && pref_q;
      end else begin
        out_mode_q <= '0;
        out_pref_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o            = '0;
    sts_o.final_acc  = accept && in_final_i;
    sts_o.blk_ok     = blk_ok_q;
    sts_o.desc_skip  = ((slot_q[0] == '0) && (slot_q[1] == '0)) || slot_q[8][7];
    sts_o.std_skip   = (slot_q[0] == 8'h01) && (slot_q[1] == 8'h01);
    sts_o.est_bit    = sup[cmd_i.est_idx];
    sts_o.div_done   = !div_busy_q;
    sts_o.mode_match = (mode_rdata == cand_q);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_mode_o   = out_mode_q;
  assign out_pref_o   = out_pref_q;
  assign out_last_o   = out_last_q;

endmodule

/* design/edid_mode_extractor_top.sv */
// Channel   Direction  tdata (low bit up)                               tuser   tlast
// s_axis    in         edid_byte [7:0]                                  -       final_byte
// m_axis    out        mode_width [11:0], mode_height [23:12],          status  run_end
//                      refresh_hz [53:24], is_preferred [54], 0 [55]
// Bytes are taken one per cycle until the final byte is accepted; the block is then checked.
// The scan takes no input: a detailed descriptor fetches its bytes one by one and is evaluated,
// and a timing then runs the 30-step restoring divider; a standard timing fetches its two bytes,
// an established bit fetches nothing, and every entry then advances. A candidate is searched
// against the stored modes in turn. Emission reads each mode out, and output backpressure stalls it.
// The last result may wait while new bytes load. Reset is asynchronous; memories are not cleared.
module edid_mode_extractor_top
  import eme_pkg::*;
#(
  parameter int unsigned MaxModes = DefMaxModes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // edid_byte
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [55:0] m_axis_tdata,  // mode_width, mode_height, refresh_hz, is_preferred
  output logic [1:0]  m_axis_tuser,  // status
  output logic        m_axis_tlast
);

  localparam int unsigned Aw = (MaxModes > 1) ? $clog2(MaxModes) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [Aw-1:0] mode_waddr, mode_raddr;
  mode_t         out_mode;
  logic          out_pref;

  eme_ctrl #(.MaxModes(MaxModes)) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .mode_waddr_o (mode_waddr),
    .mode_raddr_o (mode_raddr)
  );

  eme_dp #(.MaxModes(MaxModes)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_final_i   (s_axis_tlast),
    .out_ready_i  (m_axis_tready),
    .cmd_i        (cmd),
    .mode_waddr_i (mode_waddr),
    .mode_raddr_i (mode_raddr),
    .sts_o        (sts),
    .out_valid_o  (m_axis_tvalid),
    .out_status_o (m_axis_tuser),
    .out_mode_o   (out_mode),
    .out_pref_o   (out_pref),
    .out_last_o   (m_axis_tlast)
  );

  assign s_axis_tready = cmd.in_ready;
  assign m_axis_tdata  = {1'b0, out_pref, out_mode.refresh, out_mode.height, out_mode.width};

`ifndef ASSERT_OFF
  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == StatusMode || m_axis_tuser == StatusInvalid
                       || m_axis_tuser == StatusNoModes))
    else $error("bad status code");

  a_status_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != StatusMode) |-> (m_axis_tlast && m_axis_tdata == '0))
    else $error("status result carries mode data");

  a_no_input_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.final_acc |=> !s_axis_tready)
    else $error("input taken right after the final byte");
`endif

endmodule

/* test/edid_mode_checker.sv */
module edid_mode_checker
  import eme_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tlast,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [55:0] m_axis_tdata,
  input  logic [1:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          modes_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] width;
    logic [11:0] height;
    logic [29:0] refresh;
    logic        pref;
    logic        last;
  } mode_item_t;

  logic [7:0]  edid_store [BlockLen];
  int unsigned held_bytes;
  logic [7:0]  running_sum;
  mode_t       found_modes [$];
  mode_item_t  expected_modes [$];

  int fails;
  int seen;
  assign fail_count_o = fails;
  assign pending_o    = expected_modes.size();
  assign modes_seen_o = seen;

  task automatic report_mismatch(input string what);
    $display("[%0t] result error: %s", $realtime, what);
    fails++;
  endtask

  function automatic void add_found(input logic [11:0] w, input logic [11:0] h,
                                    input logic [29:0] r);
    mode_t m;
    m = '{w, h, r};
    if (found_modes.size() >= DefMaxModes) return;
    foreach (found_modes[k]) if (found_modes[k] == m) return;
    found_modes.push_back(m);
  endfunction

  function automatic void parse_block();
    logic        old_rev;
    logic        pref;
    logic        ok;
    int unsigned base, pclk, ha, hb, va, vb, tot, rate, w, h;
    logic [7:0]  b0, b1;
    logic [16:0] sup;
    mode_item_t  it;
    ok = held_bytes >= BlockLen && running_sum == 8'h00;
    for (int i = 0; i < 8; i++)
      if (ok && edid_store[i] != ((i == 0 || i == 7) ? 8'h00 : 8'hFF)) ok = 1'b0;
    it = '0;
    it.last = 1'b1;
    if (!ok) begin
      it.status = StatusInvalid;
      expected_modes.push_back(it);
      return;
    end
    old_rev = edid_store[18] == 8'd1 && edid_store[19] < 8'd3;
    pref = 1'b0;
    found_modes.delete();
    for (int i = 0; i < 4; i++) begin
      base = 54 + 18 * i;
      if (edid_store[base] == 0 && edid_store[base+1] == 0) continue;
      if (edid_store[base+17][7]) continue;
      pclk = {edid_store[base+1], edid_store[base]};
      ha = {edid_store[base+4][7:4], edid_store[base+2]};
      hb = {edid_store[base+4][3:0], edid_store[base+3]};
      va = {edid_store[base+7][7:4], edid_store[base+5]};
      vb = {edid_store[base+7][3:0], edid_store[base+6]};
      tot = (ha + hb) * (va + vb);
      rate = (tot == 0) ? 0 : int'((longint'(pclk) * 10000 + tot / 2) / tot);
      add_found(ha[11:0], va[11:0], rate[29:0]);
      if (i == 0 && (!old_rev || edid_store[24][1])) pref = 1'b1;
    end
    for (int i = 0; i < 8; i++) begin
      b0 = edid_store[38 + 2 * i];
      b1 = edid_store[39 + 2 * i];
      if (b0 == 8'h01 && b1 == 8'h01) continue;
      w = b0 * 8 + 248;
      case (b1[7:6])
        2'd0:    h = old_rev ? w : w * 10 / 16;
        2'd1:    h = w * 3 / 4;
        2'd2:    h = w * 4 / 5;
        default: h = w * 9 / 16;
      endcase
      add_found(w[11:0], h[11:0], 30'(b1[5:0]) + 30'd60);
    end
    sup = {edid_store[35], edid_store[36], edid_store[37][7]};
    for (int i = 0; i < 17; i++)
      if (i != 5 && sup[i]) add_found(est_mode(5'(i)).width, est_mode(5'(i)).height,
                                      est_mode(5'(i)).refresh);
    if (found_modes.size() == 0) begin
      it.status = StatusNoModes;
      expected_modes.push_back(it);
      return;
    end
    foreach (found_modes[k]) begin
      it.status  = StatusMode;
      it.width   = found_modes[k].width;
      it.height  = found_modes[k].height;
      it.refresh = found_modes[k].refresh;
      it.pref    = (k == 0) && pref;
      it.last    = k == found_modes.size() - 1;
      expected_modes.push_back(it);
    end
  endfunction

  mode_item_t got;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_bytes  = 0;
      running_sum = '0;
      fails       = 0;
      seen        = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tuser, m_axis_tdata[11:0], m_axis_tdata[23:12], m_axis_tdata[53:24],
               m_axis_tdata[54], m_axis_tlast};
        seen++;
        if (expected_modes.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer %h", got));
        end else if (got !== expected_modes[0] || m_axis_tdata[55] !== 1'b0) begin
          report_mismatch($sformatf("got %h exp %h", got, expected_modes[0]));
          void'(expected_modes.pop_front());
        end else begin
          void'(expected_modes.pop_front());
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (held_bytes < BlockLen) begin
          edid_store[held_bytes] = s_axis_tdata;
          running_sum = running_sum + s_axis_tdata;
          held_bytes = held_bytes + 1;
        end
        if (s_axis_tlast) begin
          parse_block();
          held_bytes = 0;
          running_sum = '0;
        end
      end
    end
  end
endmodule

/* test/tb_edid_mode_extractor_top.sv */
module tb_edid_mode_extractor_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [55:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count, pending, modes_seen;
  bit          calm = 1'b0;
  int          blocks_sent = 0;
  int          bytes_sent = 0;

  always #5 clk_i = ~clk_i;

  edid_mode_extractor_top u_top (.*);

  edid_mode_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .modes_seen_o(modes_seen)
  );

  int rx_hold = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (rx_hold > 0) begin
      rx_hold--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 5) == 0) rx_hold = $urandom_range(1, 4);
    end
  end

  logic [7:0] blk [$];

  task automatic send_byte(input logic [7:0] b, input logic last);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_block();
    for (int i = 0; i < blk.size(); i++) send_byte(blk[i], i == blk.size() - 1);
    s_axis_tvalid <= 1'b0;
    s_axis_tlast  <= 1'b0;
    @(posedge clk_i);
    blocks_sent++;
  endtask

  // Builds a well-formed base block with random content; kind picks the flavor.
  task automatic build_block(input int kind);
    logic [7:0] sum;
    blk.delete();
    for (int i = 0; i < 128; i++) blk.push_back(8'($urandom));
    for (int i = 0; i < 8; i++) blk[i] = (i == 0 || i == 7) ? 8'h00 : 8'hFF;
    blk[18] = 8'd1;
    blk[19] = 8'($urandom_range(0, 4));
    if (kind == 1) begin
      for (int i = 35; i < 54; i++) blk[i] = (i >= 38) ? 8'h01 : 8'h00;
      for (int i = 54; i < 126; i++) blk[i] = 8'h00;
    end else if (kind == 2) begin
      blk[35] = 8'hFF; blk[36] = 8'hFF; blk[37] = 8'hFF;
      for (int i = 38; i < 54; i++) blk[i] = 8'($urandom);
      for (int d = 0; d < 4; d++) begin
        blk[54 + 18 * d] = 8'($urandom); blk[55 + 18 * d] = 8'($urandom);
        blk[71 + 18 * d] = 8'h7F & 8'($urandom);
      end
    end else if (kind == 3) begin
      for (int i = 54; i < 126; i++) blk[i] = 8'h00;
      blk[56] = 8'h10; blk[54] = 8'h01;
    end
    sum = '0;
    for (int i = 0; i < 127; i++) sum += blk[i];
    blk[127] = -sum;
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    build_block(2); blk.push_back(8'hAA); blk.push_back(8'h55); send_block();
    blk = {8'h00}; send_block();
    build_block(0); blk = blk[0:7]; send_block();
    while (bytes_sent < 166) begin
      if (bytes_sent >= 155) calm = 1'b1;
      blk.delete();
      repeat ($urandom_range(1, 6)) blk.push_back(8'($urandom));
      send_block();
    end
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Sent %0d blocks (%0d bytes): one full block with trailing bytes, then short ones.",
             blocks_sent, bytes_sent);
    $display("Checked %0d result transfers.", modes_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("edid_mode_extractor_top: match");
    end else begin
      $display("edid_mode_extractor_top: mismatch");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("edid_mode_extractor_top: mismatch");
    $finish;
  end
endmodule

/* files.f */
design/eme_pkg.sv
design/eme_ram.sv
design/eme_ctrl.sv
design/eme_dp.sv
design/edid_mode_extractor_top.sv
test/edid_mode_checker.sv
test/tb_edid_mode_extractor_top.sv
